[src/mdbq_pkg.sv]
// ----------------------------------------------------------------------------
// mdbq_pkg
// Shared types and constants for the multidrop bus master queue.
// ----------------------------------------------------------------------------
package mdbq_pkg;

  // The ring depth must be a power of two so that the pointers wrap freely.
  localparam int RING_DEPTH = 16;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int PUSH_MAX   = 4;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    FUNC_HOST     = 2'd0,
    FUNC_SLAVE    = 2'd1,
    FUNC_TX_READY = 2'd2,
    FUNC_TX_DONE  = 2'd3
  } func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_TRIGGER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLAVE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SLAVE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_LIMIT  = 3'd4;

  typedef logic [8:0] word_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] byte_in;
  } mdbq_in_t;

  typedef struct packed {
    logic       host_valid;
    logic [7:0] host_byte;
    logic       bus_valid;
    logic [7:0] bus_byte;
    logic       bus_is_address;
    logic       drive_enable;
    logic       waiting_reply;
    logic       overflow;
  } mdbq_out_t;

  typedef struct packed {
    logic [CNT_W-1:0]           count;
    word_t [PUSH_MAX-1:0]       words;
    logic                       pop;
  } ring_req_t;

  typedef struct packed {
    logic             empty;
    logic             head_is_last;
    logic [PTR_W-1:0] free;
    word_t            head;
  } ring_stat_t;

endpackage

[src/multidrop_bus_master_queue_core.sv]
// ----------------------------------------------------------------------------
// multidrop_bus_master_queue_core
// Master side of a 9-bit multidrop bus: send ring, polling rounds and replies.
// The result passes through the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled, limited by
// the single state update per event.
// Synchronous reset clears pointers and flags and loads the configuration
// defaults; ring contents are left unset.
// ----------------------------------------------------------------------------
module multidrop_bus_master_queue_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mdbq_pkg::mdbq_in_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mdbq_pkg::mdbq_out_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mdbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import mdbq_pkg::*;

  logic       s1_valid;
  mdbq_in_t   s1_item;
  logic       s2_ready;
  logic       fire;
  ring_req_t  req;
  ring_stat_t stat;
  mdbq_out_t  result;

  assign cfg_ready = 1'b1;
  assign s2_ready  = !out_valid || !out_stall;
  assign fire      = s1_valid && s2_ready;
  assign in_stall  = s1_valid && !s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= result;
    end
  end

  mdbq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (s1_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .req       (req),
    .result    (result)
  );

  mdbq_ring u_ring (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat)
  );

endmodule

[src/mdbq_ring.sv]
// ----------------------------------------------------------------------------
// mdbq_ring
// Send ring with read and write pointers; stores up to four words at once.
// ----------------------------------------------------------------------------
module mdbq_ring (
  input  logic                clk,
  input  logic                rst,
  input  mdbq_pkg::ring_req_t req,
  output mdbq_pkg::ring_stat_t stat
);
  import mdbq_pkg::*;

  word_t            ring [RING_DEPTH];
  logic [PTR_W-1:0] read_pointer;
  logic [PTR_W-1:0] write_pointer;
  logic [CNT_W-1:0] stored;
  logic [PTR_W-1:0] free;

  localparam int CMP_W = PTR_W + CNT_W;

  assign free   = read_pointer - write_pointer - PTR_W'(1);
  assign stored = (CMP_W'(req.count) > CMP_W'(free)) ? CNT_W'(free) : req.count;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
    end else begin
      write_pointer <= write_pointer + PTR_W'(stored);
      if (req.pop) begin
        read_pointer <= read_pointer + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PUSH_MAX; i++) begin
      if (CNT_W'(i) < stored) begin
        ring[write_pointer + PTR_W'(i)] <= req.words[i];
      end
    end
  end

  assign stat.empty        = (read_pointer == write_pointer);
  assign stat.head_is_last = ((read_pointer + PTR_W'(1)) == write_pointer);
  assign stat.free         = free;
  assign stat.head         = ring[read_pointer];

endmodule

[src/mdbq_ctrl.sv]
// ----------------------------------------------------------------------------
// mdbq_ctrl
// Configuration registers, polling and reply flags, and the event decode.
// ----------------------------------------------------------------------------
module mdbq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  mdbq_pkg::mdbq_in_t         item,
  input  logic                       cfg_valid,
  input  logic [mdbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                 cfg_data,
  input  mdbq_pkg::ring_stat_t       stat,
  output mdbq_pkg::ring_req_t        req,
  output mdbq_pkg::mdbq_out_t        result
);
  import mdbq_pkg::*;

  localparam int CMP_W = PTR_W + CNT_W;

  logic [7:0] auto_trigger_code;
  logic [7:0] first_slave_address;
  logic [7:0] second_slave_address;
  logic [7:0] end_code;
  logic [2:0] round_limit;

  logic       awaiting_reply, awaiting_reply_next;
  logic       auto_active, auto_active_next;
  logic [2:0] round_count, round_count_next;
  logic       send_request, send_request_next;
  logic       driver_on, driver_on_next;

  logic       do_round;
  logic       slave_end;
  logic       awaiting_eff;
  logic [2:0] round_base;
  ring_req_t  raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_trigger_code    <= 8'd255;
      first_slave_address  <= 8'd1;
      second_slave_address <= 8'd2;
      end_code             <= 8'd4;
      round_limit          <= 3'd5;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_AUTO_TRIGGER: auto_trigger_code    <= cfg_data;
        CFG_FIRST_SLAVE:  first_slave_address  <= cfg_data;
        CFG_SECOND_SLAVE: second_slave_address <= cfg_data;
        CFG_END_CODE:     end_code             <= cfg_data;
        CFG_ROUND_LIMIT:  round_limit          <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_reply <= 1'b0;
      auto_active    <= 1'b0;
      round_count    <= '0;
      send_request   <= 1'b0;
      driver_on      <= 1'b0;
    end else if (fire) begin
      awaiting_reply <= awaiting_reply_next;
      auto_active    <= auto_active_next;
      round_count    <= round_count_next;
      send_request   <= send_request_next;
      driver_on      <= driver_on_next;
    end
  end

  always_comb begin
    awaiting_reply_next = awaiting_reply;
    auto_active_next    = auto_active;
    round_count_next    = round_count;
    send_request_next   = send_request;
    driver_on_next      = driver_on;
    raw                 = '0;
    result              = '0;
    do_round            = 1'b0;
    slave_end           = 1'b0;
    awaiting_eff        = awaiting_reply;
    round_base          = round_count;

    case (item.func)
      FUNC_HOST: begin
        if (item.byte_in != auto_trigger_code) begin
          raw.count    = CNT_W'(2);
          raw.words[0] = {1'b1, item.byte_in};
          raw.words[1] = '0;
        end else begin
          do_round   = 1'b1;
          round_base = '0;
        end
      end
      FUNC_SLAVE: begin
        result.host_valid = 1'b1;
        result.host_byte  = item.byte_in;
        if (item.byte_in == end_code) begin
          slave_end           = 1'b1;
          awaiting_eff        = 1'b0;
          awaiting_reply_next = 1'b0;
          do_round            = auto_active;
        end
      end
      FUNC_TX_READY: begin
        if (send_request) begin
          if (stat.empty) begin
            send_request_next = 1'b0;
          end else begin
            driver_on_next        = 1'b1;
            result.bus_valid      = 1'b1;
            result.bus_byte       = stat.head[7:0];
            result.bus_is_address = stat.head[8];
            raw.pop               = 1'b1;
            if (!stat.head[8]) begin
              awaiting_reply_next = 1'b1;
            end
            if (stat.head_is_last || !stat.head[8] || awaiting_reply) begin
              send_request_next = 1'b0;
            end
          end
        end
      end
      FUNC_TX_DONE: begin
        driver_on_next = 1'b0;
      end
      default: ;
    endcase

    if (do_round) begin
      raw.count        = CNT_W'(4);
      raw.words[0]     = {1'b1, first_slave_address};
      raw.words[1]     = {6'b0, round_base};
      raw.words[2]     = {1'b1, second_slave_address};
      raw.words[3]     = {6'b0, round_base};
      round_count_next = round_base + 3'd1;
      auto_active_next = (round_count_next < round_limit);
    end

    if (raw.count != '0 && !awaiting_eff) begin
      send_request_next = 1'b1;
    end
    if (slave_end && (!stat.empty || (raw.count != '0 && stat.free != '0))) begin
      send_request_next = 1'b1;
    end

    result.overflow      = (CMP_W'(raw.count) > CMP_W'(stat.free));
    result.drive_enable  = driver_on_next;
    result.waiting_reply = awaiting_reply_next;
  end

  always_comb begin
    req       = raw;
    req.count = fire ? raw.count : '0;
    req.pop   = fire & raw.pop;
  end

endmodule
